// ===== design/pidc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types and constants of the clamped pid controller
// ----------------------------------------------------------------------------
package pidc_pkg;

    // register map of the configuration port
    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PROP_GAIN     = 3'd0;
    localparam cfg_idx_t CFG_INTEG_GAIN    = 3'd1;
    localparam cfg_idx_t CFG_DERIV_GAIN    = 3'd2;
    localparam cfg_idx_t CFG_STEP_TIME     = 3'd3;
    localparam cfg_idx_t CFG_INV_STEP_TIME = 3'd4;
    localparam cfg_idx_t CFG_DRIVE_MIN     = 3'd5;
    localparam cfg_idx_t CFG_DRIVE_MAX     = 3'd6;

    // reset values of the registers
    localparam logic [23:0] PROP_GAIN_RST     = 24'd983040;
    localparam logic [23:0] INTEG_GAIN_RST    = 24'd163840;
    localparam logic [23:0] DERIV_GAIN_RST    = 24'd524288;
    localparam logic [15:0] STEP_TIME_RST     = 16'd3277;
    localparam logic [31:0] INV_STEP_TIME_RST = 32'd1310720;
    localparam logic [31:0] DRIVE_MIN_RST     = 32'd0;
    localparam logic [31:0] DRIVE_MAX_RST     = 32'd3276800;

    // saturation limits
    localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_MIN = 32'h8000_0000;
    localparam logic [47:0] I48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] I48_MIN = 48'h8000_0000_0000;

    // shared multiplier: magnitude operands, sign of the product
    localparam int MUL_A_W     = 48;
    localparam int MUL_B_W     = 32;
    localparam int MUL_DIGIT_W = 24;
    localparam int MUL_ACC_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_RES_W   = 64;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a_mag;
        logic [MUL_B_W-1:0] b_mag;
    } mul_req_t;

    typedef struct packed {
        logic                 done;
        logic [MUL_RES_W-1:0] value;
    } mul_rsp_t;

endpackage

// ===== design/pid_controller_clamped_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_unit
// positional pid controller in q16.16 with saturating integral and clamped drive
// ----------------------------------------------------------------------------
// usage
//   input channel: target and measured (signed q16.16) with in_valid; the
//   block raises in_stall while it works on a transaction
//   output channel: drive (signed q16.16) and clamped with out_valid; the
//   receiver holds out_stall high to keep the result in place
//   configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 prop_gain .. 6 drive_max); cfg_ready is always high, higher indexes
//   are dropped; write only while the block is idle
// timing
//   five products go one after another through one 24x32 multiplier, each in
//   steps (operand latch, two digits, sign and shift)
//   the result is written to the output register in the clamp state, and a new
//   input is taken only once the block is back in idle after that write
//   a result waiting under out_stall does not block the next input; only the
//   final write of the output register waits for the slot to free up
// reset
//   integral and previous error go to zero, registers to their defaults,
//   both channels idle
// ----------------------------------------------------------------------------
module pid_controller_clamped_unit (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] target,
    input  logic signed [31:0] measured,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive,
    output logic               clamped,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  pidc_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]        cfg_data
);
    import pidc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_CLAMP
    } state_t;

    // products in order; none needs the result of the one just before it
    typedef enum logic [2:0] {
        OP_INT,
        OP_DER,
        OP_P,
        OP_I,
        OP_D
    } op_t;

    // configuration registers
    logic signed [23:0] prop_gain_reg;
    logic signed [23:0] integ_gain_reg;
    logic signed [23:0] deriv_gain_reg;
    logic [15:0]        step_time_reg;
    logic [31:0]        inv_step_time_reg;
    logic signed [31:0] drive_min_reg;
    logic signed [31:0] drive_max_reg;

    // controller state and working registers
    state_t             state_reg;
    op_t                op_reg;
    logic signed [47:0] integral_reg;
    logic signed [31:0] last_error_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] delta_reg;
    logic signed [47:0] deriv_reg;
    logic signed [63:0] sum_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] drive_reg;
    logic               clamped_reg;

    // shared multiplier
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    // error, saturated to 32 bits
    logic signed [32:0] err_diff;
    logic signed [31:0] err_sat;

    // operand selection
    op_t                op_start;
    op_t                op_after;
    logic signed [47:0] a_val;
    logic signed [32:0] b_val;
    logic [47:0]        a_abs;
    logic [32:0]        b_abs;

    // result handling
    logic signed [63:0] prod;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_next;
    logic signed [47:0] deriv_next;

    // clamp
    logic signed [63:0] max_ext;
    logic signed [63:0] min_ext;
    logic               gt_max;
    logic               lt_min;
    logic               max_lt_min;
    logic signed [31:0] drive_next;
    logic               clamped_next;
    logic               out_free;

    assign err_diff = {target[31], target} - {measured[31], measured};
    assign err_sat  = (err_diff[32] != err_diff[31])
                    ? (err_diff[32] ? I32_MIN : I32_MAX) : err_diff[31:0];

    always_comb
    begin
        case (op_reg)
            OP_INT:  op_after = OP_DER;
            OP_DER:  op_after = OP_P;
            OP_P:    op_after = OP_I;
            OP_I:    op_after = OP_D;
            default: op_after = OP_D;
        endcase
        op_start = (state_reg == S_ISSUE) ? OP_INT : op_after;
    end

    // operands as signed values, then sign and magnitude
    always_comb
    begin
        case (op_start)
            OP_INT:
            begin
                a_val = 48'(err_reg);
                b_val = {17'd0, step_time_reg};
            end
            OP_DER:
            begin
                a_val = 48'(delta_reg);
                b_val = {1'b0, inv_step_time_reg};
            end
            OP_P:
            begin
                a_val = 48'(err_reg);
                b_val = 33'(prop_gain_reg);
            end
            OP_I:
            begin
                a_val = integral_reg;
                b_val = 33'(integ_gain_reg);
            end
            default:
            begin
                a_val = deriv_reg;
                b_val = 33'(deriv_gain_reg);
            end
        endcase
    end

    assign a_abs = a_val[47] ? 48'(-a_val) : 48'(a_val);
    assign b_abs = b_val[32] ? 33'(-b_val) : 33'(b_val);

    assign mul_req.start = (state_reg == S_ISSUE)
                         || (state_reg == S_WAIT && mul_rsp.done && op_reg != OP_D);
    assign mul_req.neg   = a_val[47] ^ b_val[32];
    assign mul_req.a_mag = a_abs;
    assign mul_req.b_mag = b_abs[31:0];

    pidc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign prod = $signed(mul_rsp.value);

    // integral step stays within 32 bits of magnitude, so 49 bits hold the sum
    assign integ_sum  = {integral_reg[47], integral_reg} + prod[48:0];
    assign integ_next = (integ_sum[48] != integ_sum[47])
                      ? (integ_sum[48] ? I48_MIN : I48_MAX) : integ_sum[47:0];
    assign deriv_next = (prod[63:47] == {17{prod[47]}})
                      ? prod[47:0] : (prod[63] ? I48_MIN : I48_MAX);

    // upper limit first, lower limit last
    assign max_ext    = 64'(drive_max_reg);
    assign min_ext    = 64'(drive_min_reg);
    assign gt_max     = sum_reg > max_ext;
    assign lt_min     = sum_reg < min_ext;
    assign max_lt_min = drive_max_reg < drive_min_reg;

    always_comb
    begin
        if (gt_max)
        begin
            drive_next   = max_lt_min ? drive_min_reg : drive_max_reg;
            clamped_next = max_lt_min ? (sum_reg != min_ext) : 1'b1;
        end
        else if (lt_min)
        begin
            drive_next   = drive_min_reg;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = sum_reg[31:0];
            clamped_next = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_INT;
            out_valid_reg     <= 1'b0;
            integral_reg      <= '0;
            last_error_reg    <= '0;
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            deriv_gain_reg    <= DERIV_GAIN_RST;
            step_time_reg     <= STEP_TIME_RST;
            inv_step_time_reg <= INV_STEP_TIME_RST;
            drive_min_reg     <= DRIVE_MIN_RST;
            drive_max_reg     <= DRIVE_MAX_RST;
        end
        else
        begin
            // configuration writes, always taken
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[23:0];
                    CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[23:0];
                    CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[23:0];
                    CFG_STEP_TIME:     step_time_reg     <= cfg_data[15:0];
                    CFG_INV_STEP_TIME: inv_step_time_reg <= cfg_data;
                    CFG_DRIVE_MIN:     drive_min_reg     <= cfg_data;
                    CFG_DRIVE_MAX:     drive_max_reg     <= cfg_data;
                    default:           ;
                endcase
            end

            // receiver took the result; a new result in the same cycle refills the slot
            if (out_valid_reg && !out_stall && state_reg != S_CLAMP)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg   <= err_sat;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    // multiplier starts the integral product here
                    delta_reg      <= {err_reg[31], err_reg}
                                    - {last_error_reg[31], last_error_reg};
                    last_error_reg <= err_reg;
                    op_reg         <= OP_INT;
                    state_reg      <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        case (op_reg)
                            OP_INT:  integral_reg <= integ_next;
                            OP_DER:  deriv_reg    <= deriv_next;
                            OP_P:    sum_reg      <= prod;
                            default: sum_reg      <= sum_reg + prod;
                        endcase
                        if (op_reg == OP_D)
                        begin
                            state_reg <= S_CLAMP;
                        end
                        else
                        begin
                            op_reg <= op_after;
                        end
                    end
                end
                S_CLAMP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= drive_next;
                        clamped_reg   <= clamped_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule

// ===== design/pidc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mul
// shared sign-magnitude multiplier, 24x32 bits a cycle, result >> 16 toward zero
// ----------------------------------------------------------------------------
module pidc_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pidc_pkg::mul_req_t req,
    output pidc_pkg::mul_rsp_t rsp
);
    import pidc_pkg::*;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_FIN
    } mul_state_t;

    localparam int PROD_W = MUL_DIGIT_W + MUL_B_W;

    mul_state_t           state_reg;
    logic                 digit_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_ACC_W-1:0] acc_reg;
    logic [MUL_RES_W-1:0] res_reg;

    logic [PROD_W-1:0]    prod;
    logic [MUL_ACC_W-1:0] acc_next;
    logic [MUL_RES_W-1:0] mag;

    // most significant digit first
    assign prod     = PROD_W'(a_reg[MUL_A_W-1 -: MUL_DIGIT_W]) * PROD_W'(b_reg);
    assign acc_next = {acc_reg[MUL_ACC_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                    + MUL_ACC_W'(prod);
    assign mag      = acc_reg[MUL_ACC_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            digit_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // one-cycle pulse with the result
            done_reg <= (state_reg == MS_FIN);
            case (state_reg)
                MS_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= req.a_mag;
                        b_reg     <= req.b_mag;
                        neg_reg   <= req.neg;
                        acc_reg   <= '0;
                        digit_reg <= 1'b0;
                        state_reg <= MS_RUN;
                    end
                end
                MS_RUN:
                begin
                    acc_reg   <= acc_next;
                    a_reg     <= {a_reg[MUL_A_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
                    digit_reg <= 1'b1;
                    if (digit_reg)
                    begin
                        state_reg <= MS_FIN;
                    end
                end
                MS_FIN:
                begin
                    res_reg   <= neg_reg ? (-mag) : mag;
                    state_reg <= MS_IDLE;
                end
                default:
                begin
                    state_reg <= MS_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

// ===== sim/tb_pid_controller_clamped_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped_unit
// self-checking bench for the clamped positional pid controller: a queue-fed
// driver and a posedge monitor drive the block and compare every drive value
// and clamp flag with a cycle-free fixed-point predictor of the controller
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_unit;
    import pidc_pkg::*;

    // saturation bounds of the error and the 48-bit integral / rate terms
    localparam longint ERR_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ERR_MIN = -ERR_MAX - 1;
    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    // magnitude cap of a shifted product
    localparam logic [127:0] MAG_CAP = 128'd1 << 62;
    // unmapped register index, writes to it are dropped
    localparam cfg_idx_t CFG_NONE = 3'd7;
    localparam int MAX_REPORTS = 100;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 102;

    typedef struct {
        logic [31:0] target;
        logic [31:0] measured;
    } sample_t;

    typedef struct {
        logic [31:0] drive;
        logic        clamped;
    } drive_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] target = '0;
    logic signed [31:0] measured = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] drive;
    logic               clamped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_idx_t           cfg_index = CFG_PROP_GAIN;
    logic [31:0]        cfg_data = '0;

    // pending input samples and predicted drive results
    sample_t    sample_q[$];
    drive_res_t drive_q[$];
    sample_t    next_sample;
    drive_res_t want;
    bit         in_taken = 1'b0;
    int         errors = 0;
    int         send_idle_pct = 0;
    int         rcv_idle_pct = 0;

    // predictor copy of the register file and the controller state
    longint kp = $signed(PROP_GAIN_RST);
    longint ki = $signed(INTEG_GAIN_RST);
    longint kd = $signed(DERIV_GAIN_RST);
    longint dt = STEP_TIME_RST;
    longint inv_dt = INV_STEP_TIME_RST;
    longint lim_lo = $signed(DRIVE_MIN_RST);
    longint lim_hi = $signed(DRIVE_MAX_RST);
    longint integ = 0;
    longint prev_err = 0;

    pid_controller_clamped_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .clamped   (clamped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // exact signed product shifted right by 16, truncated toward zero
    function automatic longint mul_q16(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        longint       mag;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        prod = prod >> 16;
        if (prod > MAG_CAP)
            prod = MAG_CAP;
        mag = prod[63:0];
        return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    // one controller step: update integral and previous error, queue the drive
    task automatic predict_drive(input logic signed [31:0] tgt,
                                 input logic signed [31:0] meas);
        longint     err;
        longint     rate;
        longint     sum;
        longint     out;
        drive_res_t res;
        err = clip(longint'(tgt) - longint'(meas), ERR_MIN, ERR_MAX);
        integ = clip(integ + mul_q16(err, dt), ACC_MIN, ACC_MAX);
        rate = clip(mul_q16(err - prev_err, inv_dt), ACC_MIN, ACC_MAX);
        prev_err = err;
        sum = mul_q16(err, kp) + mul_q16(integ, ki) + mul_q16(rate, kd);
        // upper limit first, lower limit wins when the limits are inverted
        out = sum;
        if (out > lim_hi)
            out = lim_hi;
        if (out < lim_lo)
            out = lim_lo;
        res.drive = out[31:0];
        res.clamped = (out != sum);
        drive_q.push_back(res);
    endtask

    task automatic apply_reg(input cfg_idx_t idx, input logic [31:0] data);
        case (idx)
            CFG_PROP_GAIN:     kp = $signed(data[23:0]);
            CFG_INTEG_GAIN:    ki = $signed(data[23:0]);
            CFG_DERIV_GAIN:    kd = $signed(data[23:0]);
            CFG_STEP_TIME:     dt = data[15:0];
            CFG_INV_STEP_TIME: inv_dt = data;
            CFG_DRIVE_MIN:     lim_lo = $signed(data);
            CFG_DRIVE_MAX:     lim_hi = $signed(data);
            default:           ;
        endcase
    endtask

    // one register write transaction, the predictor follows at the accepting edge
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_sample(input logic [31:0] tgt, input logic [31:0] meas);
        sample_t s;
        s.target = tgt;
        s.measured = meas;
        sample_q.push_back(s);
    endtask

    // wait until every queued sample went in and every result came out
    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report(input string what, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, what, exp_v, got_v);
    endtask

    function automatic logic [31:0] corner_value();
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // gains: full words (upper byte ignored), moderate values of both signs, extremes
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF);
            2: return -$urandom_range(0, 32'h000F_FFFF);
            3: return $urandom_range(0, 32'h0003_FFFF);
            default:
            begin
                case ($urandom_range(2))
                    0:       return 32'h007F_FFFF;
                    1:       return 32'h0080_0000;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // input driver: next transaction at the falling edge, random sender gaps
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_sample = sample_q.pop_front();
                target <= next_sample.target;
                measured <= next_sample.measured;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        // receiver back-pressure, independent of the output state
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // monitor: results are checked before the same-edge input is predicted
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, drive %h clamped %b",
                             $time, drive, clamped);
            end
            else
            begin
                want = drive_q.pop_front();
                if (drive !== want.drive)
                    report("drive", want.drive, drive);
                if (clamped !== want.clamped)
                    report("clamped", {31'd0, want.clamped}, {31'd0, clamped});
            end
        end
        if (in_valid && !in_stall)
        begin
            predict_drive(target, measured);
            in_taken = 1'b1;
        end
    end

    // stimulus sequence
    initial
    begin
        longint      sp;
        longint      pv;
        logic [31:0] lo;
        logic [31:0] hi;
        int          pick;
        sp = 0;
        pv = 0;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // slow receiver while the directed part runs
        send_idle_pct = 31;
        rcv_idle_pct = 83;

        // default registers; the first transaction sees a previous error of zero
        add_sample(32'd655360, 32'd0);
        add_sample(32'd0, 32'd0);
        // error saturation in both directions and the swing between them
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'h8000_0000, 32'h8000_0000);
        add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h0000_0000);
        add_sample(32'h0000_0000, 32'h8000_0000);
        add_sample(32'hFFFF_FFFF, 32'h0000_0001);
        add_sample(32'h0000_0001, 32'hFFFF_FFFF);
        // realistic tracking, then hits of the upper and lower drive limits
        add_sample(32'd1310720, 32'd1277952);
        add_sample(32'd1310720, 32'd1310720);
        add_sample(32'd1638400, 32'd655360);
        add_sample(32'd327680, 32'd655360);
        wait_drained();

        // every register at an extreme: the derivative term saturates both ways
        write_reg(CFG_PROP_GAIN, 32'h007F_FFFF);
        write_reg(CFG_INTEG_GAIN, 32'h0080_0000);
        write_reg(CFG_DERIV_GAIN, 32'h007F_FFFF);
        write_reg(CFG_STEP_TIME, 32'h0000_FFFF);
        write_reg(CFG_INV_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_DRIVE_MIN, 32'h8000_0000);
        write_reg(CFG_DRIVE_MAX, 32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'h0000_0000, 32'h0000_0000);
        add_sample(32'h0000_0001, 32'h0000_0000);
        wait_drained();

        // zero step time, zero reciprocal, inverted limits, dropped index
        write_reg(CFG_PROP_GAIN, 32'hFF01_0000);
        write_reg(CFG_STEP_TIME, 32'hABCD_0000);
        write_reg(CFG_INV_STEP_TIME, 32'h0000_0000);
        write_reg(CFG_DRIVE_MIN, 32'd6553600);
        write_reg(CFG_DRIVE_MAX, -32'd6553600);
        write_reg(CFG_NONE, 32'h1234_5678);
        add_sample(32'd0, 32'd0);
        add_sample(32'd65536000, 32'd0);
        add_sample(-32'd65536000, 32'd0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // slow receiver, then slow sender, then full rate
            if (ph < 4)
            begin
                send_idle_pct = 31;
                rcv_idle_pct = 83;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 83;
                rcv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // fresh register set for the phase, block is idle here
            write_reg(CFG_PROP_GAIN, pick_gain());
            write_reg(CFG_INTEG_GAIN, pick_gain());
            write_reg(CFG_DERIV_GAIN, pick_gain());
            case ($urandom_range(2))
                0:       write_reg(CFG_STEP_TIME, $urandom());
                1:       write_reg(CFG_STEP_TIME, $urandom_range(1, 32'h0000_FFFF));
                default: write_reg(CFG_STEP_TIME, ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF);
            endcase
            case ($urandom_range(2))
                0:       write_reg(CFG_INV_STEP_TIME, $urandom());
                1:       write_reg(CFG_INV_STEP_TIME, $urandom_range(1, 32'h0064_0000));
                default: write_reg(CFG_INV_STEP_TIME, corner_value());
            endcase
            case ($urandom_range(3))
                0:
                begin
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                end
                1:
                begin
                    lo = $urandom();
                    hi = $urandom();
                end
                2:
                begin
                    lo = -$urandom_range(0, 32'h0100_0000);
                    hi = $urandom_range(0, 32'h0100_0000);
                end
                default:
                begin
                    lo = DRIVE_MIN_RST;
                    hi = DRIVE_MAX_RST;
                end
            endcase
            write_reg(CFG_DRIVE_MIN, lo);
            write_reg(CFG_DRIVE_MAX, hi);
            if ($urandom_range(3) == 0)
                write_reg(CFG_NONE, $urandom());

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    add_sample($urandom(), $urandom());
                else if (pick == 1)
                    add_sample(corner_value(), corner_value());
                else
                begin
                    // setpoint steps now and then, the measurement settles toward it
                    if ($urandom_range(15) == 0)
                    begin
                        if ($urandom_range(3) == 0)
                            sp = longint'(int'($urandom())) >>> 1;
                        else
                            sp = longint'($urandom_range(0, 32'h00C8_0000)) - 64'sd6553600;
                    end
                    pv = pv + (sp - pv) / longint'($urandom_range(2, 8))
                         + longint'($urandom_range(0, 32'h0002_0000)) - 64'sd65536;
                    add_sample(sp[31:0], pv[31:0]);
                end
            end
            wait_drained();
        end

        // room for any stray result after the last expected one
        repeat (30)
            @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pidc_pkg.sv
design/pidc_mul.sv
design/pid_controller_clamped_unit.sv
sim/tb_pid_controller_clamped_unit.sv
